// ===== hdl/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg: shared types and constants for the parallel port register block
// Access and result word layouts, offset, kind and event codes, reset values.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [1:0] OFF_PORT_A  = 2'd0;
  localparam logic [1:0] OFF_PORT_B  = 2'd1;
  localparam logic [1:0] OFF_PORT_C  = 2'd2;
  localparam logic [1:0] OFF_CONTROL = 2'd3;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_RAISED  = 2'd1;
  localparam logic [1:0] EV_LOWERED = 2'd2;

  localparam logic [7:0] LATCH_RESET   = 8'hFF;
  localparam logic [7:0] CONTROL_RESET = 8'h9B;
  localparam logic [2:0] SELECT_RESET  = 3'd7;
  localparam logic [2:0] SELECT_DEV0   = 3'd0;

  // Control word bit positions.
  localparam int CW_MODE_SET = 7;
  localparam int CW_A_IN     = 4;
  localparam int CW_CH_IN    = 3;
  localparam int CW_B_IN     = 1;
  localparam int CW_CL_IN    = 0;

  typedef struct packed {
    logic       kind;
    logic [1:0] offset;
    logic [7:0] wdata;
  } ppr_access_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [7:0] port_a_pins;
    logic [7:0] port_c_pins;
    logic [1:0] select_event;
  } ppr_result_t;

endpackage

// ===== hdl/ppr_access_unit.sv =====
// ----------------------------------------------------------------------------
// ppr_access_unit: port latches, control word and chip-select tracking
// Computes the result of one access and commits the state when enabled.
// ----------------------------------------------------------------------------
module ppr_access_unit
  import ppr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        card_present,
  input  logic        commit,
  input  ppr_access_t acc,
  output ppr_result_t res
);

  logic [7:0] latch_a_r, latch_a_nxt;
  logic [7:0] latch_b_r, latch_b_nxt;
  logic [7:0] latch_c_r, latch_c_nxt;
  logic [7:0] control_r, control_nxt;
  logic [2:0] last_sel_r, last_sel_nxt;
  logic [7:0] rdata;
  logic [1:0] sel_event;
  logic [2:0] sel_now;

  always_comb begin
    latch_a_nxt  = latch_a_r;
    latch_b_nxt  = latch_b_r;
    latch_c_nxt  = latch_c_r;
    control_nxt  = control_r;
    last_sel_nxt = last_sel_r;
    rdata        = 8'h00;
    sel_event    = EV_NONE;
    sel_now      = 3'd0;
    if (acc.kind == KIND_WRITE) begin
      unique case (acc.offset)
        OFF_PORT_A: latch_a_nxt = acc.wdata;
        OFF_PORT_B: latch_b_nxt = acc.wdata;
        OFF_PORT_C: latch_c_nxt = acc.wdata;
        OFF_CONTROL: begin
          if (acc.wdata[CW_MODE_SET]) begin
            control_nxt = acc.wdata;
          end else begin
            // Bit set/reset: bits 3..1 pick the port C bit, bit 0 is its value.
            latch_c_nxt[acc.wdata[3:1]] = acc.wdata[0];
          end
        end
        default: latch_a_nxt = latch_a_r;
      endcase
      sel_now = latch_c_nxt[2:0];
      if (card_present && (sel_now != last_sel_r)) begin
        if (last_sel_r == SELECT_DEV0) begin
          sel_event = EV_RAISED;
        end else if (sel_now == SELECT_DEV0) begin
          sel_event = EV_LOWERED;
        end
        last_sel_nxt = sel_now;
      end
    end else begin
      unique case (acc.offset)
        OFF_PORT_A: rdata = control_r[CW_A_IN] ? 8'hFF : latch_a_r;
        OFF_PORT_B: rdata = control_r[CW_B_IN] ? 8'hFF : latch_b_r;
        OFF_PORT_C: begin
          rdata[3:0] = control_r[CW_CL_IN] ? 4'hF : latch_c_r[3:0];
          rdata[7:4] = control_r[CW_CH_IN] ? 4'hF : latch_c_r[7:4];
        end
        OFF_CONTROL: rdata = control_r;
        default: rdata = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_a_r  <= LATCH_RESET;
      latch_b_r  <= LATCH_RESET;
      latch_c_r  <= LATCH_RESET;
      control_r  <= CONTROL_RESET;
      last_sel_r <= SELECT_RESET;
    end else if (commit) begin
      latch_a_r  <= latch_a_nxt;
      latch_b_r  <= latch_b_nxt;
      latch_c_r  <= latch_c_nxt;
      control_r  <= control_nxt;
      last_sel_r <= last_sel_nxt;
    end
  end

  assign res.rdata        = rdata;
  assign res.port_a_pins  = latch_a_nxt;
  assign res.port_c_pins  = latch_c_nxt;
  assign res.select_event = sel_event;

endmodule

// ===== hdl/parallel_port_registers_core.sv =====
// ----------------------------------------------------------------------------
// parallel_port_registers_core: mode-0 three-port parallel interface registers
// Input word register, access unit, result register with valid/ready on both.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              contents
//   in_       input      in_valid / in_ready    kind, offset, wdata
//   out_      output     out_valid / out_ready  rdata, port A/C pins, event
//   cfg_      input      cfg_wr_en (no wait)    card_present
//
// A word is taken every cycle while in_ready is high; its result is presented
// when the word moves from the input register into the result register.
// The access unit commits state as the word moves into the result register.
// A stalled result register holds the input register, which then holds
// in_ready low. Reset (synchronous, rst_n low) empties both stages.
//
module parallel_port_registers_core
  import ppr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [1:0] in_offset,
  input  logic [7:0] in_wdata,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_rdata,
  output logic [7:0] out_port_a_pins,
  output logic [7:0] out_port_c_pins,
  output logic [1:0] out_select_event
);

  logic        card_present_r;
  logic        s1_valid_r;
  ppr_access_t s1_acc_r;
  logic        out_valid_r;
  ppr_result_t out_res_r;
  ppr_result_t res;
  logic        out_free;
  logic        s1_move;

  assign out_free = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      card_present_r <= 1'b0;
    end else if (cfg_wr_en) begin
      card_present_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_acc_r.kind   <= in_kind;
      s1_acc_r.offset <= in_offset;
      s1_acc_r.wdata  <= in_wdata;
    end
  end

  ppr_access_unit u_access (
    .clk          (clk),
    .rst_n        (rst_n),
    .card_present (card_present_r),
    .commit       (s1_move),
    .acc          (s1_acc_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rdata        = out_res_r.rdata;
  assign out_port_a_pins  = out_res_r.port_a_pins;
  assign out_port_c_pins  = out_res_r.port_c_pins;
  assign out_select_event = out_res_r.select_event;

endmodule

// ===== hdl/ppr_checker.sv =====
// ----------------------------------------------------------------------------
// ppr_checker: port-level checks for the parallel port register block
// Attached to the top level by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
module ppr_checker
  import ppr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_rdata,
  input logic [7:0] out_port_a_pins,
  input logic [7:0] out_port_c_pins,
  input logic [1:0] out_select_event
);

  // A stalled result word keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rdata) &&
      $stable(out_port_a_pins) && $stable(out_port_c_pins) && $stable(out_select_event))
    else $error("stalled result word changed");

  // Reset empties the result register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Select events come only from writes, and writes read back zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_select_event != EV_NONE) |-> out_rdata == 8'h00)
    else $error("select event on a read word");

  // A result after an empty output comes from a word taken through the input register.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input word");

endmodule

bind parallel_port_registers_core ppr_checker u_ppr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_rdata        (out_rdata),
  .out_port_a_pins  (out_port_a_pins),
  .out_port_c_pins  (out_port_c_pins),
  .out_select_event (out_select_event)
);

// ===== verif/parallel_port_registers_core_tb.sv =====
// ----------------------------------------------------------------------------
// parallel_port_registers_core_tb: self-checking bench for the PPI registers
// Bus accesses go through a queue-fed driver. Each accepted word is run
// through a behavioral model of the latches, control word and chip select.
// A monitor compares every result word with the oldest prediction. A run
// covers directed corner cases and random traffic with and without a card.
// ----------------------------------------------------------------------------
module parallel_port_registers_core_tb
  import ppr_pkg::*;
();

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_kind = KIND_READ;
  logic [1:0] in_offset = OFF_PORT_A;
  logic [7:0] in_wdata = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_rdata;
  logic [7:0] out_port_a_pins;
  logic [7:0] out_port_c_pins;
  logic [1:0] out_select_event;

  // Model state of the part.
  logic [7:0] pa_latch = LATCH_RESET;
  logic [7:0] pb_latch = LATCH_RESET;
  logic [7:0] pc_latch = LATCH_RESET;
  logic [7:0] ctrl_word = CONTROL_RESET;
  logic [2:0] cs_last = SELECT_RESET;
  logic       card_on = 1'b0;

  ppr_access_t access_q[$];
  ppr_result_t bus_result_q[$];
  ppr_access_t next_word;
  ppr_result_t want;
  bit          steady = 1'b0;
  int          errors = 0;
  int          words_taken = 0;
  int          events_seen = 0;
  int          card_writes = 0;

  parallel_port_registers_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_offset        (in_offset),
    .in_wdata         (in_wdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_rdata        (out_rdata),
    .out_port_a_pins  (out_port_a_pins),
    .out_port_c_pins  (out_port_c_pins),
    .out_select_event (out_select_event)
  );

  always #6 clk = ~clk;

  // Applies one bus access to the model and returns the result word it causes.
  function automatic ppr_result_t apply_access(ppr_access_t acc);
    ppr_result_t r;
    logic [2:0]  now_sel;
    r = '0;
    r.select_event = EV_NONE;
    if (acc.kind == KIND_WRITE) begin
      case (acc.offset)
        OFF_PORT_A: pa_latch = acc.wdata;
        OFF_PORT_B: pb_latch = acc.wdata;
        OFF_PORT_C: pc_latch = acc.wdata;
        default: begin
          if (acc.wdata[CW_MODE_SET]) begin
            ctrl_word = acc.wdata;
          end else begin
            pc_latch[acc.wdata[3:1]] = acc.wdata[0];
          end
        end
      endcase
      now_sel = pc_latch[2:0];
      // The remembered select only follows port C while a card is attached.
      if (card_on && now_sel != cs_last) begin
        if (cs_last == SELECT_DEV0) begin
          r.select_event = EV_RAISED;
        end else if (now_sel == SELECT_DEV0) begin
          r.select_event = EV_LOWERED;
        end
        cs_last = now_sel;
      end
    end else begin
      case (acc.offset)
        OFF_PORT_A: r.rdata = ctrl_word[CW_A_IN] ? 8'hFF : pa_latch;
        OFF_PORT_B: r.rdata = ctrl_word[CW_B_IN] ? 8'hFF : pb_latch;
        OFF_PORT_C: r.rdata = {ctrl_word[CW_CH_IN] ? 4'hF : pc_latch[7:4],
                               ctrl_word[CW_CL_IN] ? 4'hF : pc_latch[3:0]};
        default:    r.rdata = ctrl_word;
      endcase
    end
    r.port_a_pins = pa_latch;
    r.port_c_pins = pc_latch;
    return r;
  endfunction

  // Driver: predicts each word as it is taken and presents the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        bus_result_q.push_back(apply_access({in_kind, in_offset, in_wdata}));
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (access_q.size() != 0 && (steady || $urandom_range(99) >= 22)) begin
          next_word = access_q.pop_front();
          in_valid  <= 1'b1;
          in_kind   <= next_word.kind;
          in_offset <= next_word.offset;
          in_wdata  <= next_word.wdata;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the result channel at random and checks each result word.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 22);
      if (out_valid && out_ready) begin
        if (bus_result_q.size() == 0) begin
          $error("result word with no access pending");
          errors++;
        end else begin
          want = bus_result_q.pop_front();
          if (out_rdata !== want.rdata) begin
            $error("rdata: expected %02h, got %02h", want.rdata, out_rdata);
            errors++;
          end
          if (out_port_a_pins !== want.port_a_pins) begin
            $error("port_a_pins: expected %02h, got %02h", want.port_a_pins,
                   out_port_a_pins);
            errors++;
          end
          if (out_port_c_pins !== want.port_c_pins) begin
            $error("port_c_pins: expected %02h, got %02h", want.port_c_pins,
                   out_port_c_pins);
            errors++;
          end
          if (out_select_event !== want.select_event) begin
            $error("select_event: expected %0d, got %0d", want.select_event,
                   out_select_event);
            errors++;
          end
          if (want.select_event != EV_NONE) events_seen++;
        end
      end
    end
  end

  task automatic queue_word(logic kind, logic [1:0] offset, logic [7:0] wdata);
    ppr_access_t w;
    w.kind   = kind;
    w.offset = offset;
    w.wdata  = wdata;
    access_q.push_back(w);
  endtask

  // Waits until every queued word is taken and every result word has come.
  task automatic drain();
    while (access_q.size() != 0 || in_valid || bus_result_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_card(logic on);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    card_on = on;
    card_writes++;
    @(negedge clk);
  endtask

  // Random traffic weighted toward port C so that the select often moves
  // into and out of device 0.
  task automatic queue_random(int n);
    ppr_access_t w;
    int          pick;
    for (int i = 0; i < n; i++) begin
      pick    = $urandom_range(99);
      w.wdata = 8'($urandom);
      if (pick < 30) begin
        w.kind   = KIND_READ;
        w.offset = 2'($urandom);
      end else if (pick < 50) begin
        w.kind   = KIND_WRITE;
        w.offset = OFF_PORT_C;
        if ($urandom_range(9) < 3) w.wdata[2:0] = SELECT_DEV0;
      end else if (pick < 75) begin
        w.kind   = KIND_WRITE;
        w.offset = OFF_CONTROL;
        w.wdata[CW_MODE_SET] = 1'b0;
        if ($urandom_range(3) != 0) w.wdata[3:1] = 3'($urandom_range(2));
      end else if (pick < 85) begin
        w.kind   = KIND_WRITE;
        w.offset = OFF_CONTROL;
        w.wdata[CW_MODE_SET] = 1'b1;
      end else begin
        w.kind   = KIND_WRITE;
        w.offset = $urandom_range(1) ? OFF_PORT_A : OFF_PORT_B;
      end
      access_q.push_back(w);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values, and a port C write with no card attached.
    queue_word(KIND_READ, OFF_PORT_A, 8'h00);
    queue_word(KIND_READ, OFF_PORT_B, 8'hFF);
    queue_word(KIND_READ, OFF_PORT_C, 8'h00);
    queue_word(KIND_READ, OFF_CONTROL, 8'h00);
    queue_word(KIND_WRITE, OFF_PORT_C, 8'h00);
    drain();

    set_card(1'b1);
    queue_word(KIND_WRITE, OFF_PORT_C, 8'h00);   // select enters device 0
    queue_word(KIND_WRITE, OFF_CONTROL, 8'h03);  // bit 1 set: select leaves it
    queue_word(KIND_WRITE, OFF_CONTROL, 8'h0E);  // bit 7 cleared: select unchanged
    queue_word(KIND_WRITE, OFF_CONTROL, 8'h05);  // moves between other devices
    queue_word(KIND_WRITE, OFF_CONTROL, 8'h80);  // all ports output
    queue_word(KIND_WRITE, OFF_PORT_A, 8'hA5);
    queue_word(KIND_WRITE, OFF_PORT_B, 8'h5A);
    queue_word(KIND_WRITE, OFF_PORT_C, 8'hC8);
    queue_word(KIND_READ, OFF_PORT_A, 8'hFF);
    queue_word(KIND_READ, OFF_PORT_B, 8'h00);
    queue_word(KIND_READ, OFF_PORT_C, 8'hFF);
    queue_word(KIND_WRITE, OFF_CONTROL, 8'h81);  // port C low nibble input
    queue_word(KIND_READ, OFF_PORT_C, 8'h00);
    queue_word(KIND_WRITE, OFF_CONTROL, 8'h88);  // port C high nibble input
    queue_word(KIND_READ, OFF_PORT_C, 8'h00);
    queue_word(KIND_WRITE, OFF_CONTROL, 8'h92);  // ports A and B input
    queue_word(KIND_WRITE, OFF_PORT_A, 8'h00);   // latch still takes the byte
    queue_word(KIND_READ, OFF_PORT_A, 8'h00);
    queue_word(KIND_READ, OFF_CONTROL, 8'h00);
    queue_word(KIND_WRITE, OFF_PORT_C, 8'hFF);
    drain();

    // First random phase runs with no idling on either side.
    steady = 1'b1;
    queue_random(170);
    drain();
    steady = 1'b0;

    set_card(1'b0);
    queue_random(150);
    drain();

    set_card(1'b1);
    queue_random(170);
    drain();

    set_card(1'b1);
    queue_random(160);
    drain();

    repeat (10) @(negedge clk);
    $display("Ran %0d bus accesses across %0d card setting writes; %0d select events.",
             words_taken, card_writes, events_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("status: fail");
    $finish;
  end

endmodule
